FILE: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, codes and control types of the sbus frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 5;
  localparam int VAL_W       = 12;
  localparam int RAW_W       = 11;
  localparam int DATA_BYTES  = 22;
  localparam int DATA_W      = DATA_BYTES * BYTE_W;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] FLAG_POS    = CNT_W'(DATA_BYTES);
  localparam logic [CNT_W-1:0] NUM_ANALOG  = CNT_W'(16);
  localparam logic [CNT_W-1:0] LAST_CH     = CNT_W'(17);

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;

  localparam logic [BYTE_W-1:0] START_RESET = 8'h0F;
  localparam logic [BYTE_W-1:0] END_RESET   = 8'h00;

  localparam int LOST_BIT = 2;
  localparam int DIG0_BIT = 0;
  localparam int DIG1_BIT = 1;

  localparam logic signed [VAL_W-1:0] FULL_SCALE = 12'sd1024;
  localparam logic signed [VAL_W-1:0] DIG_HIGH   = 12'sd800;
  localparam logic signed [VAL_W-1:0] DIG_LOW    = -12'sd800;

  typedef struct packed {
    logic             shift_byte;
    logic             latch_flags;
    logic             load_out;
    logic             shift_chan;
    logic             lost;
    logic [IDX_W-1:0] idx;
  } sfd_cmd_t;

  typedef struct packed {
    logic start_hit;
    logic end_hit;
    logic frame_lost;
  } sfd_stat_t;

endpackage

FILE: rtl/sfd_in_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if
// Received byte stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfd_in_if
  import sfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/sfd_out_if.sv
// ----------------------------------------------------------------------------
// sfd_out_if
// Decoded channel result stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfd_out_if
  import sfd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    frame_status;
  logic [IDX_W-1:0]        channel_index;
  logic signed [VAL_W-1:0] channel_value;
  logic                    last_item;

  modport source (output valid, output frame_status, output channel_index,
                  output channel_value, output last_item, input ready);
  modport sink   (input valid, input frame_status, input channel_index,
                  input channel_value, input last_item, output ready);
endinterface

FILE: rtl/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath
// Config registers, frame shift register, flag byte and result register.
// ----------------------------------------------------------------------------
module sfd_datapath
  import sfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [BYTE_W-1:0]       cfg_data,
  input  logic [BYTE_W-1:0]       rx_byte,
  input  sfd_cmd_t                cmd,
  output sfd_stat_t               stat,
  output logic                    frame_status,
  output logic [IDX_W-1:0]        channel_index,
  output logic signed [VAL_W-1:0] channel_value,
  output logic                    last_item
);

  logic [BYTE_W-1:0]       start_byte_r, start_byte_nxt;
  logic [BYTE_W-1:0]       end_byte_r, end_byte_nxt;
  logic [DATA_W-1:0]       data_r, data_nxt;
  logic [BYTE_W-1:0]       flags_r, flags_nxt;
  logic                    status_r, status_nxt;
  logic [IDX_W-1:0]        index_r, index_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    last_r, last_nxt;
  logic [RAW_W-1:0]        raw;

  assign raw = data_r[RAW_W-1:0];

  always_comb begin
    start_byte_nxt = start_byte_r;
    end_byte_nxt   = end_byte_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE: start_byte_nxt = cfg_data;
        CFG_END_BYTE:   end_byte_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    data_nxt  = data_r;
    flags_nxt = flags_r;
    if (cmd.shift_byte) begin
      data_nxt = {rx_byte, data_r[DATA_W-1:BYTE_W]};
    end else if (cmd.shift_chan) begin
      data_nxt = data_r >> RAW_W;
    end
    if (cmd.latch_flags) begin
      flags_nxt = rx_byte;
    end
  end

  always_comb begin
    status_nxt = status_r;
    index_nxt  = index_r;
    value_nxt  = value_r;
    last_nxt   = last_r;
    if (cmd.load_out) begin
      if (cmd.lost) begin
        status_nxt = 1'b1;
        index_nxt  = '0;
        value_nxt  = '0;
        last_nxt   = 1'b1;
      end else begin
        status_nxt = 1'b0;
        index_nxt  = cmd.idx;
        last_nxt   = (cmd.idx == LAST_CH);
        if (cmd.idx < NUM_ANALOG) begin
          value_nxt = FULL_SCALE - $signed({1'b0, raw});
        end else if (cmd.idx == LAST_CH) begin
          value_nxt = flags_r[DIG1_BIT] ? DIG_HIGH : DIG_LOW;
        end else begin
          value_nxt = flags_r[DIG0_BIT] ? DIG_HIGH : DIG_LOW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_RESET;
      end_byte_r   <= END_RESET;
    end else begin
      start_byte_r <= start_byte_nxt;
      end_byte_r   <= end_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    flags_r  <= flags_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
    value_r  <= value_nxt;
    last_r   <= last_nxt;
  end

  assign stat.start_hit  = (rx_byte == start_byte_r);
  assign stat.end_hit    = (rx_byte == end_byte_r);
  assign stat.frame_lost = flags_r[LOST_BIT];

  assign frame_status  = status_r;
  assign channel_index = index_r;
  assign channel_value = value_r;
  assign last_item     = last_r;

endmodule

FILE: rtl/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame parse state machine and result sequencer.
// ----------------------------------------------------------------------------
module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  sfd_stat_t stat,
  output sfd_cmd_t  cmd
);

  localparam logic [1:0] ST_SYNC = 2'd0;
  localparam logic [1:0] ST_DATA = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lost_r, lost_nxt;
  logic             valid_r, valid_nxt;
  logic             accept;
  logic             slot_free;
  logic             done;

  assign in_ready  = (state_r != ST_EMIT);
  assign accept    = in_valid && in_ready;
  assign slot_free = !valid_r || out_ready;
  assign done      = lost_r || (cnt_r == LAST_CH);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lost_nxt  = lost_r;
    cmd       = '0;
    cmd.lost  = lost_r;
    cmd.idx   = IDX_W'(cnt_r);
    case (state_r)
      ST_SYNC: begin
        if (accept && stat.start_hit) begin
          state_nxt = ST_DATA;
          cnt_nxt   = '0;
        end
      end
      ST_DATA: begin
        if (accept) begin
          if (cnt_r == FLAG_POS) begin
            cmd.latch_flags = 1'b1;
            state_nxt       = ST_END;
            cnt_nxt         = '0;
          end else begin
            cmd.shift_byte = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
          end
        end
      end
      ST_END: begin
        if (accept) begin
          if (stat.end_hit) begin
            state_nxt = ST_EMIT;
            lost_nxt  = stat.frame_lost;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_SYNC;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out   = 1'b1;
          cmd.shift_chan = !lost_r && (cnt_r < NUM_ANALOG);
          if (done) begin
            state_nxt = ST_SYNC;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_SYNC;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.load_out) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC;
      cnt_r   <= '0;
      lost_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lost_r  <= lost_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

`ifndef NO_ASSERTIONS
  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> (cnt_r <= FLAG_POS))
    else $error("byte count past flag byte");

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r <= LAST_CH))
    else $error("result count past last channel");

  a_lost_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && lost_r) |-> (cnt_r == '0))
    else $error("frame lost run has more than one result");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && done) |=> (state_r == ST_SYNC && out_valid))
    else $error("result run did not end after last beat");
`endif

endmodule

FILE: rtl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Results: a matching end byte enters the emit state, which registers results.
// Throughput: one byte per cycle while syncing and collecting; after a good end
// byte the input stalls while the emit counter sends 18 results (or one on
// frame lost), one per cycle when the sink is ready.
// Reset: synchronous rst_n, waits for start byte; start 0x0F, end 0x00.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  sfd_in_if.sink               in_ch,
  sfd_out_if.source            out_ch
);

  sfd_cmd_t  cmd;
  sfd_stat_t stat;

  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (in_ch.rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .frame_status  (out_ch.frame_status),
    .channel_index (out_ch.channel_index),
    .channel_value (out_ch.channel_value),
    .last_item     (out_ch.last_item)
  );

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for sbus_frame_decoder. Received bytes go in as beats on the
// input channel, and decoded channel results come back on the output channel.
// A directed table of frames covers these cases: all-zero and all-one data,
// the digital flags, frame lost, and a bad end byte. Random traffic follows,
// over several start and end byte settings: good frames, lost frames, bad end
// bytes, cut-off frames and noise. Both sides stall at random, and at one
// point the result side holds off long enough that the input backs up. Every
// result beat is compared with the row's values for typed table rows, else
// with a local decoder kept in step with accepted input beats.
// ----------------------------------------------------------------------------
module tb
  import sfd_pkg::*;
();

  localparam int FRAME_LEN = 23;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 600;

  typedef struct packed {
    logic                    status;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } chan_t;

  typedef enum logic [1:0] {PH_HUNT, PH_FILL, PH_TAIL} parse_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_LOST, EXP_CHANNELS} exp_kind_t;

  typedef struct {
    logic [7:0]              lead;
    bit                      has_lead;
    logic [7:0]              fill;
    logic [7:0]              flags;
    bit                      end_ok;
    exp_kind_t               kind;
    logic signed [VAL_W-1:0] analog;
    logic signed [VAL_W-1:0] dig0;
    logic signed [VAL_W-1:0] dig1;
  } frame_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  sbus_frame_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // decoder state mirrored from accepted beats
  parse_t      ph = PH_HUNT;
  logic [4:0]  fill_cnt = '0;
  logic [7:0]  frame_buf [FRAME_LEN] = '{default: 8'h00};
  logic [7:0]  start_reg = START_RESET;
  logic [7:0]  end_reg = END_RESET;

  chan_t       chan_q [$];
  chan_t       typed_q [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          in_quiet = 0;
  bit          out_quiet = 0;
  logic        hold_req;
  bit          hold_done = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  frame_row_t frame_rows [9] = '{
    '{8'hF0, 1, 8'h00, 8'h00, 1, EXP_CHANNELS, 12'sd1024, -12'sd800, -12'sd800},
    '{8'h00, 0, 8'hFF, 8'h03, 1, EXP_CHANNELS, -12'sd1023, 12'sd800, 12'sd800},
    '{8'h00, 1, 8'hAA, 8'h04, 1, EXP_LOST, 12'sd0, 12'sd0, 12'sd0},
    '{8'h00, 0, 8'hFF, 8'hFF, 1, EXP_LOST, 12'sd0, 12'sd0, 12'sd0},
    '{8'h00, 0, 8'h55, 8'h00, 0, EXP_NONE, 12'sd0, 12'sd0, 12'sd0},
    '{8'h00, 0, 8'h00, 8'hFB, 1, EXP_CHANNELS, 12'sd1024, 12'sd800, 12'sd800},
    '{8'h00, 0, 8'h0F, 8'h01, 1, EXP_MODEL, 12'sd0, 12'sd0, 12'sd0},
    '{8'hFF, 1, 8'hA5, 8'h02, 1, EXP_MODEL, 12'sd0, 12'sd0, 12'sd0},
    '{8'h00, 0, 8'h3C, 8'hF8, 1, EXP_MODEL, 12'sd0, 12'sd0, 12'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void decode_beat(input logic [7:0] b, output chan_t res [$]);
    logic [DATA_W-1:0] bits;
    logic [RAW_W-1:0]  raw;
    logic [7:0]        flags;
    int                i;
    res.delete();
    case (ph)
      PH_FILL: begin
        frame_buf[fill_cnt] = b;
        fill_cnt = fill_cnt + 1'b1;
        if (fill_cnt == FRAME_LEN) begin
          fill_cnt = '0;
          ph = PH_TAIL;
        end
      end
      PH_TAIL: begin
        ph = PH_HUNT;
        if (b == end_reg) begin
          flags = frame_buf[FLAG_POS];
          if (flags[LOST_BIT]) begin
            res.push_back('{1'b1, '0, '0, 1'b1});
          end else begin
            for (i = 0; i < DATA_BYTES; i++) bits[i*BYTE_W +: BYTE_W] = frame_buf[i];
            for (i = 0; i < 16; i++) begin
              raw = bits[i*RAW_W +: RAW_W];
              res.push_back('{1'b0, IDX_W'(i), FULL_SCALE - VAL_W'(raw), 1'b0});
            end
            res.push_back('{1'b0, IDX_W'(16), flags[DIG0_BIT] ? 12'sd800 : -12'sd800, 1'b0});
            res.push_back('{1'b0, IDX_W'(17), flags[DIG1_BIT] ? 12'sd800 : -12'sd800, 1'b1});
          end
        end
      end
      default: begin
        ph = PH_HUNT;
        if (b == start_reg) begin
          ph = PH_FILL;
          fill_cnt = '0;
        end
      end
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] bad_tail();
    return (start_reg != end_reg) ? start_reg : ~end_reg;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed);
    chan_t res [$];
    int    gap;
    if (!in_quiet && $urandom_range(0, 3) == 0) begin
      gap = gap_len();
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_beat(b, res);
    if (typed) res = typed_q;
    foreach (res[k]) chan_q.push_back(res[k]);
  endtask

  task automatic send_frame(input logic [7:0] body [FRAME_LEN], input logic [7:0] tail,
                            input bit typed);
    send_byte(start_reg, 1'b0);
    foreach (body[i]) send_byte(body[i], 1'b0);
    send_byte(tail, typed);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chan_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_END_BYTE;
    cfg_data  <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_reg = s;
    end_reg   = e;
  endtask

  task automatic random_traffic(input int n_bytes);
    logic [7:0] body [FRAME_LEN];
    logic [7:0] tail;
    int         sent;
    int         kind;
    int         fill_mode;
    int         cut;
    sent = 0;
    while (sent < n_bytes) begin
      kind      = $urandom_range(0, 19);
      fill_mode = $urandom_range(0, 9);
      foreach (body[i])
        body[i] = (fill_mode == 0) ? 8'h00 : (fill_mode == 1) ? 8'hFF : 8'($urandom);
      body[FLAG_POS][LOST_BIT] = 1'b0;
      tail = end_reg;
      if (kind < 2) begin
        cut = $urandom_range(1, 4);
        for (int i = 0; i < cut; i++) send_byte(8'($urandom), 1'b0);
        sent += cut;
      end else if (kind == 2) begin
        // cut-off frame, the next start byte lands in the data
        cut = $urandom_range(1, FRAME_LEN - 1);
        send_byte(start_reg, 1'b0);
        for (int i = 0; i < cut; i++) send_byte(body[i], 1'b0);
        sent += cut + 1;
      end else begin
        if (kind < 5) tail = ($urandom_range(0, 1) == 0) ? bad_tail()
                                                         : end_reg ^ (8'h01 << $urandom_range(0, 7));
        else if (kind < 8) body[FLAG_POS][LOST_BIT] = 1'b1;
        send_frame(body, tail, 1'b0);
        sent += FRAME_LEN + 2;
      end
    end
  endtask

  // cycle count, quiet stretches and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 150 == 0) begin
      in_quiet  <= ($urandom_range(0, 3) == 0);
      out_quiet <= ($urandom_range(0, 3) == 0);
    end
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_done    <= 1'b1;
      hold_left    <= HOLD_LEN - 1;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!out_quiet && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= gap_len() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result beat checker
  always @(posedge clk) begin
    chan_t got;
    chan_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.frame_status, out_ch.channel_index, out_ch.channel_value,
              out_ch.last_item};
      if (chan_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status %0d idx %0d value %0d last %0d",
                   got.status, got.idx, got.value, got.last);
      end else begin
        want = chan_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d idx %0d value %0d last %0d, got %0d %0d %0d %0d",
                     want.status, want.idx, want.value, want.last,
                     got.status, got.idx, got.value, got.last);
        end
      end
    end
  end

  initial begin
    frame_row_t row;
    logic [7:0] body [FRAME_LEN];
    logic [7:0] s_val;
    logic [7:0] e_val;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_START_BYTE;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    hold_req      <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b1;

    foreach (frame_rows[r]) begin
      row = frame_rows[r];
      typed_q.delete();
      case (row.kind)
        EXP_LOST: typed_q.push_back('{1'b1, '0, '0, 1'b1});
        EXP_CHANNELS: begin
          for (int ch = 0; ch < 16; ch++) typed_q.push_back('{1'b0, IDX_W'(ch), row.analog, 1'b0});
          typed_q.push_back('{1'b0, IDX_W'(16), row.dig0, 1'b0});
          typed_q.push_back('{1'b0, IDX_W'(17), row.dig1, 1'b1});
        end
        default: ;
      endcase
      if (row.has_lead) send_byte(row.lead, 1'b0);
      foreach (body[i]) body[i] = row.fill;
      body[FLAG_POS] = row.flags;
      send_frame(body, row.end_ok ? end_reg : bad_tail(), row.kind != EXP_MODEL);
    end
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin s_val = 8'h00; e_val = 8'hFF; end
        1: begin s_val = 8'hFF; e_val = 8'h00; end
        2: begin s_val = 8'hA5; e_val = 8'hA5; end
        3: begin s_val = 8'($urandom); e_val = 8'($urandom); end
        default: begin s_val = START_RESET; e_val = END_RESET; end
      endcase
      set_config(s_val, e_val);
      random_traffic(20);
      settle();
    end

    in_ch.valid <= 1'b0;
    while (chan_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
